// File: sv/bracket_token_collector_unit_assert.svh
// ----------------------------------------------------------------------------
// Bracket token collector assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BRACKET_TOKEN_COLLECTOR_UNIT_ASSERT_SVH
`define BRACKET_TOKEN_COLLECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BTC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/btc_pkg.sv
// ----------------------------------------------------------------------------
// Bracket token collector package
// Sizes, character codes and the structs passed between the units.
// ----------------------------------------------------------------------------
package btc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int NAME_LEN      = 32;

    localparam int SLOT_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CHAR_W  = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
    localparam int LEN_W   = $clog2(NAME_LEN + 1);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int NAMES_DEPTH = 1 << (SLOT_W + CHAR_W);
    localparam int TOK_DEPTH   = 1 << CHAR_W;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_R_UP   = 8'h52;
    localparam logic [7:0] CH_R_LO   = 8'h72;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_M_UP   = 8'h4D;
    localparam logic [7:0] CH_M_LO   = 8'h6D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic ACT_CLEAR = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_CHAR   = 1'b1;

    typedef struct packed {
        logic              en;
        logic [CHAR_W-1:0] addr;
        logic [7:0]        data;
    } tok_wr_t;

    typedef struct packed {
        logic             close;
        logic [LEN_W-1:0] tok_len;
    } scan_evt_t;

endpackage

// File: sv/btc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module btc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/btc_line_scan.sv
// ----------------------------------------------------------------------------
// Bracket token collector line scanner
// Per-byte line state, comment detection and token capture.
// ----------------------------------------------------------------------------
module btc_line_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                action,
    input  logic [7:0]          data_byte,
    output btc_pkg::tok_wr_t    tok_wr,
    output btc_pkg::scan_evt_t  evt
);

    typedef enum logic [2:0] {
        PH_BLANK,
        PH_R,
        PH_RE,
        PH_REM,
        PH_SCAN,
        PH_COMMENT
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic                        open_reg, open_next;
    logic                        stopped_reg, stopped_next;
    logic [btc_pkg::LEN_W-1:0]   len_reg, len_next;
    logic                        skip;
    logic                        is_name;
    logic                        is_blank;

    always_comb
    begin
        is_name  = data_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                                     btc_pkg::CH_UNDER};
        is_blank = data_byte inside {btc_pkg::CH_SPACE, btc_pkg::CH_TAB};
    end

    always_comb
    begin
        phase_next   = phase_reg;
        open_next    = open_reg;
        stopped_next = stopped_reg;
        len_next     = len_reg;
        skip         = 1'b0;
        tok_wr.en    = 1'b0;
        tok_wr.addr  = len_reg[btc_pkg::CHAR_W-1:0];
        tok_wr.data  = data_byte;
        evt.close    = 1'b0;
        evt.tok_len  = len_reg;

        if (accept)
        begin
            if (action == btc_pkg::ACT_CLEAR || data_byte == btc_pkg::CH_LF)
            begin
                phase_next   = PH_BLANK;
                open_next    = 1'b0;
                stopped_next = 1'b0;
                len_next     = '0;
            end
            else if (data_byte == btc_pkg::CH_CR || stopped_reg || phase_reg == PH_COMMENT)
            begin
                skip = 1'b1;
            end
            else if (data_byte == btc_pkg::CH_NUL)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_BLANK:
                    begin
                        if (is_blank)
                        begin
                            skip = 1'b1;
                        end
                        else if (data_byte inside {btc_pkg::CH_R_UP, btc_pkg::CH_R_LO})
                        begin
                            skip       = 1'b1;
                            phase_next = PH_R;
                        end
                    end
                    PH_R:
                    begin
                        if (data_byte inside {btc_pkg::CH_E_UP, btc_pkg::CH_E_LO})
                        begin
                            skip       = 1'b1;
                            phase_next = PH_RE;
                        end
                    end
                    PH_RE:
                    begin
                        if (data_byte inside {btc_pkg::CH_M_UP, btc_pkg::CH_M_LO})
                        begin
                            skip       = 1'b1;
                            phase_next = PH_REM;
                        end
                    end
                    PH_REM:
                    begin
                        if (is_blank)
                        begin
                            skip       = 1'b1;
                            phase_next = PH_COMMENT;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (!skip)
                begin
                    phase_next = PH_SCAN;
                    if (data_byte == btc_pkg::CH_LBRACK)
                    begin
                        open_next = 1'b1;
                        len_next  = '0;
                    end
                    else if (open_reg)
                    begin
                        if (data_byte == btc_pkg::CH_RBRACK)
                        begin
                            evt.close = 1'b1;
                            open_next = 1'b0;
                        end
                        else if (is_name && len_reg < btc_pkg::LEN_W'(btc_pkg::NAME_LEN))
                        begin
                            tok_wr.en = 1'b1;
                            len_next  = len_reg + btc_pkg::LEN_W'(1);
                        end
                        else
                        begin
                            open_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_BLANK;
            open_reg    <= 1'b0;
            stopped_reg <= 1'b0;
            len_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            open_reg    <= open_next;
            stopped_reg <= stopped_next;
            len_reg     <= len_next;
        end
    end

endmodule

// File: sv/btc_table_seq.sv
// ----------------------------------------------------------------------------
// Bracket token collector table sequencer
// Byte-serial duplicate search, name insertion and result generation.
// ----------------------------------------------------------------------------
module btc_table_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       action,
    input  btc_pkg::scan_evt_t         evt,
    input  logic [7:0]                 tok_rd,
    output logic [btc_pkg::CHAR_W-1:0] tok_raddr,
    output logic                       busy,
    output logic                       strobe,
    output logic                       kind,
    output logic [3:0]                 entry_index,
    output logic [7:0]                 name_char,
    output logic                       last,
    output logic [4:0]                 entry_count,
    output logic                       table_full
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENTRY,
        S_RD,
        S_CHK,
        S_CPY_RD,
        S_CPY_WR
    } state_t;

    state_t                       state_reg, state_next;
    logic [btc_pkg::SLOT_W-1:0]   e_reg, e_next;
    logic [btc_pkg::CHAR_W-1:0]   j_reg, j_next;
    logic [btc_pkg::LEN_W-1:0]    tlen_reg, tlen_next;
    logic [btc_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                         strobe_reg, strobe_next;
    logic                         kind_reg, kind_next;
    logic [3:0]                   index_reg, index_next;
    logic [7:0]                   char_reg, char_next;
    logic                         last_reg, last_next;
    logic [4:0]                   cnt_reg, cnt_next;
    logic                         full_reg, full_next;

    logic [btc_pkg::LEN_W-1:0]    len_rd;
    logic                         len_we;
    logic                         names_we;
    logic [7:0]                   names_rd;
    logic                         last_j;
    logic                         last_e;
    logic                         do_status;
    logic                         do_char;
    logic [btc_pkg::CNT_W-1:0]    count_inc;

    btc_ram #(
        .WIDTH (8),
        .DEPTH (btc_pkg::NAMES_DEPTH)
    ) u_names (
        .clk   (clk),
        .we    (names_we),
        .waddr ({count_reg[btc_pkg::SLOT_W-1:0], j_reg}),
        .wdata (tok_rd),
        .raddr ({e_reg, j_reg}),
        .rdata (names_rd)
    );

    // read on the next entry index so the length is ready in S_ENTRY
    btc_ram #(
        .WIDTH (btc_pkg::LEN_W),
        .DEPTH (btc_pkg::TABLE_ENTRIES)
    ) u_lens (
        .clk   (clk),
        .we    (len_we),
        .waddr (count_reg[btc_pkg::SLOT_W-1:0]),
        .wdata (tlen_reg),
        .raddr (e_next),
        .rdata (len_rd)
    );

    assign tok_raddr = j_reg;
    assign last_j    = btc_pkg::LEN_W'(j_reg) == tlen_reg - btc_pkg::LEN_W'(1);
    assign last_e    = btc_pkg::CNT_W'(e_reg) + btc_pkg::CNT_W'(1) == count_reg;
    assign count_inc = count_reg + btc_pkg::CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        e_next     = e_reg;
        j_next     = j_reg;
        tlen_next  = tlen_reg;
        count_next = count_reg;
        do_status  = 1'b0;
        do_char    = 1'b0;
        names_we   = 1'b0;
        len_we     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == btc_pkg::ACT_CLEAR)
                    begin
                        count_next = '0;
                        do_status  = 1'b1;
                    end
                    else if (evt.close && evt.tok_len != '0 &&
                             count_reg < btc_pkg::CNT_W'(btc_pkg::TABLE_ENTRIES))
                    begin
                        tlen_next  = evt.tok_len;
                        e_next     = '0;
                        j_next     = '0;
                        state_next = (count_reg == '0) ? S_CPY_RD : S_ENTRY;
                    end
                    else
                    begin
                        do_status = 1'b1;
                    end
                end
            end
            S_ENTRY:
            begin
                j_next = '0;
                if (len_rd == tlen_reg)
                begin
                    state_next = S_RD;
                end
                else if (last_e)
                begin
                    state_next = S_CPY_RD;
                end
                else
                begin
                    e_next = e_reg + btc_pkg::SLOT_W'(1);
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (names_rd != tok_rd)
                begin
                    j_next = '0;
                    if (last_e)
                    begin
                        state_next = S_CPY_RD;
                    end
                    else
                    begin
                        e_next     = e_reg + btc_pkg::SLOT_W'(1);
                        state_next = S_ENTRY;
                    end
                end
                else if (last_j)
                begin
                    do_status  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next     = j_reg + btc_pkg::CHAR_W'(1);
                    state_next = S_RD;
                end
            end
            S_CPY_RD:
            begin
                state_next = S_CPY_WR;
            end
            S_CPY_WR:
            begin
                names_we = 1'b1;
                do_char  = 1'b1;
                if (last_j)
                begin
                    len_we     = 1'b1;
                    count_next = count_inc;
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next     = j_reg + btc_pkg::CHAR_W'(1);
                    state_next = S_CPY_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        strobe_next = do_status | do_char;
        kind_next   = kind_reg;
        index_next  = index_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;
        full_next   = full_reg;
        if (do_status)
        begin
            kind_next  = btc_pkg::KIND_STATUS;
            index_next = '0;
            char_next  = '0;
            last_next  = 1'b1;
            cnt_next   = 5'(count_next);
            full_next  = count_next >= btc_pkg::CNT_W'(btc_pkg::TABLE_ENTRIES);
        end
        else if (do_char)
        begin
            kind_next  = btc_pkg::KIND_CHAR;
            index_next = 4'(count_reg[btc_pkg::SLOT_W-1:0]);
            char_next  = tok_rd;
            last_next  = last_j;
            cnt_next   = 5'(count_inc);
            full_next  = count_inc >= btc_pkg::CNT_W'(btc_pkg::TABLE_ENTRIES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            e_reg      <= '0;
            j_reg      <= '0;
            tlen_reg   <= '0;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
            kind_reg   <= btc_pkg::KIND_STATUS;
            index_reg  <= '0;
            char_reg   <= '0;
            last_reg   <= 1'b0;
            cnt_reg    <= '0;
            full_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            e_reg      <= e_next;
            j_reg      <= j_next;
            tlen_reg   <= tlen_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
            kind_reg   <= kind_next;
            index_reg  <= index_next;
            char_reg   <= char_next;
            last_reg   <= last_next;
            cnt_reg    <= cnt_next;
            full_reg   <= full_next;
        end
    end

    assign busy        = state_reg != S_IDLE;
    assign strobe      = strobe_reg;
    assign kind        = kind_reg;
    assign entry_index = index_reg;
    assign name_char   = char_reg;
    assign last        = last_reg;
    assign entry_count = cnt_reg;
    assign table_full  = full_reg;

endmodule

// File: sv/bracket_token_collector_unit.sv
// ----------------------------------------------------------------------------
// Bracket token collector
// Collects distinct [name] tokens from script text into a name table.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  command  | start / busy       | action, data_byte
//  result   | strobe (no stall)  | kind, entry_index, name_char, last,
//           |                    | entry_count, table_full
//
//  A byte or clear transfer that starts no search gives one status result
//  the next cycle; busy stays low, so one transfer per cycle is taken.
//  A closing bracket raises busy for the search: S_ENTRY visits each entry,
//  S_RD/S_CHK compare characters on equal lengths, S_CPY_RD/S_CPY_WR copy
//  and emit a new name. The single names-RAM read port makes this serial.
//  Reset is immediate: no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "bracket_token_collector_unit_assert.svh"

module bracket_token_collector_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       action,
    input  logic [7:0] data_byte,
    output logic       strobe,
    output logic       kind,
    output logic [3:0] entry_index,
    output logic [7:0] name_char,
    output logic       last,
    output logic [4:0] entry_count,
    output logic       table_full
);

    logic                       accept;
    btc_pkg::tok_wr_t           tok_wr;
    btc_pkg::scan_evt_t         evt;
    logic [btc_pkg::CHAR_W-1:0] tok_raddr;
    logic [7:0]                 tok_rd;
    logic                       full_expect;

    assign accept      = start & ~busy;
    assign full_expect = entry_count >= 5'(btc_pkg::TABLE_ENTRIES);

    btc_line_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (action),
        .data_byte (data_byte),
        .tok_wr    (tok_wr),
        .evt       (evt)
    );

    btc_ram #(
        .WIDTH (8),
        .DEPTH (btc_pkg::TOK_DEPTH)
    ) u_token (
        .clk   (clk),
        .we    (tok_wr.en),
        .waddr (tok_wr.addr),
        .wdata (tok_wr.data),
        .raddr (tok_raddr),
        .rdata (tok_rd)
    );

    btc_table_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (action),
        .evt         (evt),
        .tok_rd      (tok_rd),
        .tok_raddr   (tok_raddr),
        .busy        (busy),
        .strobe      (strobe),
        .kind        (kind),
        .entry_index (entry_index),
        .name_char   (name_char),
        .last        (last),
        .entry_count (entry_count),
        .table_full  (table_full)
    );

    `BTC_ASSERT_IMP(a_status_last, strobe && kind == btc_pkg::KIND_STATUS, last, "status not last")
    `BTC_ASSERT_NEXT(a_accept_answered, accept, strobe || busy, "transfer left unanswered")
    `BTC_ASSERT_IMP(a_full_count, strobe, table_full == full_expect, "full flag mismatch")

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bracket token collector testbench
// Feeds script text, byte and clear transfers, through the start/busy port
// and checks every result strobe against an in-bench model of the name
// table and the line scanner. A short table of directed text comes first,
// then random lines built from tokens, REM prefixes, noise and line ends.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_ITEMS  = 330;
    localparam int QUIET_TAIL    = 60;
    localparam int CYCLE_LIMIT   = 2_500_000;
    localparam int DRAIN_CYCLES  = 1200;
    localparam int POOL_SIZE     = 8;
    localparam int DIRECTED_ROWS = 32;

    typedef enum logic [2:0] {
        LP_LEAD,
        LP_R,
        LP_RE,
        LP_REM,
        LP_SCAN,
        LP_REMARK
    } text_phase_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] slot;
        logic [7:0] ch;
        logic       last;
        logic [4:0] count;
        logic       full;
    } name_result_t;

    typedef struct packed {
        logic       act;
        logic [7:0] text;
        logic       fixed;
        logic [4:0] count;
        logic       full;
    } text_row_t;

    // fixed rows carry the status result that follows from them directly
    localparam text_row_t DIRECTED_TEXT [DIRECTED_ROWS] = '{
        '{btc_pkg::ACT_CLEAR, 8'hA5,              1'b1, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  8'hFF,              1'b1, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_LBRACK, 1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_RBRACK, 1'b1, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_LBRACK, 1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  "Z",                1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_RBRACK, 1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_LBRACK, 1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  "Z",                1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_RBRACK, 1'b1, 5'd1, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_CR,     1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_LF,     1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_R_LO,   1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_E_UP,   1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_M_LO,   1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_TAB,    1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_LBRACK, 1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  "q",                1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_RBRACK, 1'b1, 5'd1, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_LF,     1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_LBRACK, 1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_NUL,    1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_RBRACK, 1'b1, 5'd1, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_LF,     1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_LBRACK, 1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  "-",                1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_UNDER,  1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_RBRACK, 1'b1, 5'd1, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_LBRACK, 1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  "0",                1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_LF,     1'b0, 5'd0, 1'b0},
        '{btc_pkg::ACT_DATA,  btc_pkg::CH_RBRACK, 1'b1, 5'd1, 1'b0}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       action;
    logic [7:0] data_byte;
    logic       strobe;
    logic       kind;
    logic [3:0] entry_index;
    logic [7:0] name_char;
    logic       last;
    logic [4:0] entry_count;
    logic       table_full;

    // model state
    logic        tok_open;
    logic [7:0]  tok_buf [btc_pkg::NAME_LEN];
    int          tok_len;
    text_phase_t phase;
    logic        line_halted;
    logic [7:0]  name_table [btc_pkg::TABLE_ENTRIES][btc_pkg::NAME_LEN];
    int          entry_len [btc_pkg::TABLE_ENTRIES];
    int          name_count;

    name_result_t awaited_results [$];
    logic [8:0]   text_q [$];
    logic [7:0]   pool_chars [POOL_SIZE][btc_pkg::NAME_LEN];
    int           pool_len [POOL_SIZE];

    logic idle_on;
    int   items_sent;
    int   clears_sent;
    int   names_inserted;
    int   results_checked;
    int   mismatches;
    int   cycle_count;

    bracket_token_collector_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .data_byte   (data_byte),
        .strobe      (strobe),
        .kind        (kind),
        .entry_index (entry_index),
        .name_char   (name_char),
        .last        (last),
        .entry_count (entry_count),
        .table_full  (table_full)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void restart_line();
        tok_open    = 1'b0;
        tok_len     = 0;
        phase       = LP_LEAD;
        line_halted = 1'b0;
    endfunction

    function automatic bit is_name_char(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9") || b == btc_pkg::CH_UNDER;
    endfunction

    function automatic int store_token();
        int i;
        int j;
        bit same;
        if (name_count >= btc_pkg::TABLE_ENTRIES || tok_len == 0 ||
            tok_len > btc_pkg::NAME_LEN)
            return -1;
        for (i = 0; i < name_count; i++)
        begin
            if (entry_len[i] == tok_len)
            begin
                same = 1'b1;
                for (j = 0; j < tok_len; j++)
                    if (name_table[i][j] != tok_buf[j])
                        same = 1'b0;
                if (same)
                    return -1;
            end
        end
        for (j = 0; j < tok_len; j++)
            name_table[name_count][j] = tok_buf[j];
        entry_len[name_count] = tok_len;
        name_count++;
        return name_count - 1;
    endfunction

    function automatic int bracket_byte(input logic [7:0] b);
        int slot;
        slot = -1;
        if (b == btc_pkg::CH_LBRACK)
        begin
            tok_open = 1'b1;
            tok_len  = 0;
        end
        else if (tok_open)
        begin
            if (b == btc_pkg::CH_RBRACK)
            begin
                slot     = store_token();
                tok_open = 1'b0;
            end
            else if (is_name_char(b) && tok_len < btc_pkg::NAME_LEN)
            begin
                tok_buf[tok_len] = b;
                tok_len++;
            end
            else
                tok_open = 1'b0;
        end
        return slot;
    endfunction

    function automatic int text_byte(input logic [7:0] b);
        bit blank;
        blank = (b == btc_pkg::CH_SPACE || b == btc_pkg::CH_TAB);
        if (b == btc_pkg::CH_CR)
            return -1;
        if (b == btc_pkg::CH_LF)
        begin
            restart_line();
            return -1;
        end
        if (line_halted || phase == LP_REMARK)
            return -1;
        if (b == btc_pkg::CH_NUL)
        begin
            line_halted = 1'b1;
            return -1;
        end
        case (phase)
            LP_LEAD:
            begin
                if (blank)
                    return -1;
                if (b == btc_pkg::CH_R_UP || b == btc_pkg::CH_R_LO)
                begin
                    phase = LP_R;
                    return -1;
                end
            end
            LP_R:
            begin
                if (b == btc_pkg::CH_E_UP || b == btc_pkg::CH_E_LO)
                begin
                    phase = LP_RE;
                    return -1;
                end
            end
            LP_RE:
            begin
                if (b == btc_pkg::CH_M_UP || b == btc_pkg::CH_M_LO)
                begin
                    phase = LP_REM;
                    return -1;
                end
            end
            LP_REM:
            begin
                if (blank)
                begin
                    phase = LP_REMARK;
                    return -1;
                end
            end
            default:
            begin
            end
        endcase
        phase = LP_SCAN;
        return bracket_byte(b);
    endfunction

    function automatic void collect_byte(input logic act, input logic [7:0] b);
        int           slot;
        int           k;
        name_result_t r;
        slot = -1;
        if (act == btc_pkg::ACT_CLEAR)
        begin
            restart_line();
            name_count = 0;
        end
        else
            slot = text_byte(b);
        r.count = 5'(name_count);
        r.full  = (name_count >= btc_pkg::TABLE_ENTRIES);
        if (slot < 0)
        begin
            r.kind = btc_pkg::KIND_STATUS;
            r.slot = 4'd0;
            r.ch   = 8'd0;
            r.last = 1'b1;
            awaited_results.push_back(r);
        end
        else
        begin
            names_inserted++;
            for (k = 0; k < entry_len[slot]; k++)
            begin
                r.kind = btc_pkg::KIND_CHAR;
                r.slot = 4'(slot);
                r.ch   = name_table[slot][k];
                r.last = (k + 1 == entry_len[slot]);
                awaited_results.push_back(r);
            end
        end
    endfunction

    function automatic logic [7:0] random_name_char();
        int sel;
        sel = $urandom_range(0, 62);
        if (sel < 26)
            return "a" + 8'(sel);
        if (sel < 52)
            return "A" + 8'(sel - 26);
        if (sel < 62)
            return "0" + 8'(sel - 52);
        return btc_pkg::CH_UNDER;
    endfunction

    function automatic void push_text(input logic [7:0] c);
        text_q.push_back({btc_pkg::ACT_DATA, c});
    endfunction

    function automatic void queue_token();
        logic [7:0] chars [btc_pkg::NAME_LEN + 3];
        logic [7:0] c;
        int         len;
        int         p;
        int         k;
        int         sel;
        push_text(btc_pkg::CH_LBRACK);
        if ($urandom_range(0, 9) < 5)
        begin
            p = $urandom_range(0, POOL_SIZE - 1);
            for (k = 0; k < pool_len[p]; k++)
                push_text(pool_chars[p][k]);
        end
        else
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                len = 0;
            else if (sel == 1)
                len = btc_pkg::NAME_LEN;
            else if (sel == 2)
                len = btc_pkg::NAME_LEN + 1 + $urandom_range(0, 2);
            else if (sel == 3)
                len = $urandom_range(5, btc_pkg::NAME_LEN - 1);
            else
                len = $urandom_range(1, 4);
            for (k = 0; k < len; k++)
            begin
                chars[k] = random_name_char();
                push_text(chars[k]);
            end
            if (len >= 1 && len <= btc_pkg::NAME_LEN && $urandom_range(0, 3) == 0)
            begin
                p = $urandom_range(0, POOL_SIZE - 1);
                pool_len[p] = len;
                for (k = 0; k < len; k++)
                    pool_chars[p][k] = chars[k];
            end
        end
        sel = $urandom_range(0, 11);
        if (sel == 0)
        begin
            c = 8'($urandom_range(0, 255));
            while (is_name_char(c))
                c = 8'($urandom_range(0, 255));
            push_text(c);
            push_text(btc_pkg::CH_RBRACK);
        end
        else if (sel == 2)
        begin
            push_text(btc_pkg::CH_CR);
            push_text(btc_pkg::CH_RBRACK);
        end
        else if (sel != 1)
            push_text(btc_pkg::CH_RBRACK);
    endfunction

    function automatic void queue_line();
        int k;
        int n;
        int sel;
        int seg;
        n = $urandom_range(0, 2);
        for (k = 0; k < n; k++)
            push_text($urandom_range(0, 1) ? btc_pkg::CH_SPACE : btc_pkg::CH_TAB);
        sel = $urandom_range(0, 9);
        if (sel <= 1)
        begin
            push_text($urandom_range(0, 1) ? btc_pkg::CH_R_UP : btc_pkg::CH_R_LO);
            push_text($urandom_range(0, 1) ? btc_pkg::CH_E_UP : btc_pkg::CH_E_LO);
            if (sel == 0)
            begin
                push_text($urandom_range(0, 1) ? btc_pkg::CH_M_UP : btc_pkg::CH_M_LO);
                case ($urandom_range(0, 5))
                    0: push_text(btc_pkg::CH_SPACE);
                    1: push_text(btc_pkg::CH_TAB);
                    2: push_text(btc_pkg::CH_LF);
                    3: push_text(btc_pkg::CH_NUL);
                    4: push_text("X");
                    default: push_text(btc_pkg::CH_LBRACK);
                endcase
            end
        end
        n = $urandom_range(1, 4);
        for (seg = 0; seg < n; seg++)
        begin
            sel = $urandom_range(0, 19);
            if (sel <= 11)
                queue_token();
            else if (sel <= 14)
            begin
                for (k = $urandom_range(1, 3); k > 0; k--)
                    push_text(8'($urandom_range(0, 255)));
            end
            else if (sel == 15)
                push_text(btc_pkg::CH_NUL);
            else if (sel == 16)
                push_text(btc_pkg::CH_CR);
            else
            begin
                for (k = $urandom_range(1, 3); k > 0; k--)
                    push_text(random_name_char());
            end
        end
        if ($urandom_range(0, 3) == 0)
            push_text(btc_pkg::CH_CR);
        push_text(btc_pkg::CH_LF);
        if ($urandom_range(0, 24) == 0)
            text_q.push_back({btc_pkg::ACT_CLEAR, 8'($urandom_range(0, 255))});
    endfunction

    task automatic send_text(input logic act, input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start     <= 1'b1;
        action    <= act;
        data_byte <= b;
        do
            @(posedge clk);
        while (busy);
        collect_byte(act, b);
        items_sent++;
        if (act == btc_pkg::ACT_CLEAR)
            clears_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        name_result_t want;
        if (rst_n && strobe)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"unexpected result: kind %0d slot %0d char %02h",
                              " last %0d count %0d full %0d"},
                             kind, entry_index, name_char, last, entry_count, table_full);
            end
            else
            begin
                want = awaited_results.pop_front();
                results_checked++;
                if (kind !== want.kind || entry_index !== want.slot ||
                    name_char !== want.ch || last !== want.last ||
                    entry_count !== want.count || table_full !== want.full)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp kind %0d slot %0d char %02h last %0d",
                                  " count %0d full %0d, got kind %0d slot %0d",
                                  " char %02h last %0d count %0d full %0d"},
                                 want.kind, want.slot, want.ch, want.last,
                                 want.count, want.full,
                                 kind, entry_index, name_char, last,
                                 entry_count, table_full);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        text_row_t row;
        logic [8:0] item;
        int i;
        int k;
        int items_random;
        rst_n           = 1'b0;
        start           = 1'b0;
        action          = btc_pkg::ACT_DATA;
        data_byte       = 8'd0;
        idle_on         = 1'b1;
        items_sent      = 0;
        clears_sent     = 0;
        names_inserted  = 0;
        results_checked = 0;
        mismatches      = 0;
        cycle_count     = 0;
        items_random    = 0;
        name_count      = 0;
        restart_line();
        for (i = 0; i < POOL_SIZE; i++)
        begin
            pool_len[i] = (i == POOL_SIZE - 1) ? btc_pkg::NAME_LEN : $urandom_range(1, 4);
            for (k = 0; k < pool_len[i]; k++)
                pool_chars[i][k] = random_name_char();
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED_TEXT[i];
            send_text(row.act, row.text);
            if (row.fixed)
            begin
                void'(awaited_results.pop_back());
                awaited_results.push_back(name_result_t'{btc_pkg::KIND_STATUS, 4'd0, 8'd0,
                                                         1'b1, row.count, row.full});
            end
        end
        settle();

        text_q.push_back({btc_pkg::ACT_CLEAR, 8'h00});
        while (items_random < RANDOM_ITEMS)
        begin
            if (items_random % 25 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (items_random >= RANDOM_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;
            if (text_q.size() == 0)
                queue_line();
            item = text_q.pop_front();
            send_text(item[8], item[7:0]);
            items_random++;
            if (items_random == RANDOM_ITEMS / 2)
                settle();
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transfers (%0d directed, %0d clears), %0d names inserted",
                 items_sent, DIRECTED_ROWS, clears_sent, names_inserted);
        $display("checked %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
